// ----- rtl/core/wnntc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnntc_pkg
// Shared types and constants of the weighted nearest-neighbor timing
// classifier: defaults, opcodes, controller states, command/status bundles.
// ----------------------------------------------------------------------------
package wnntc_pkg;

  localparam int MAX_SAMPLES_DEF     = 64;
  localparam int TIME_BITS_DEF       = 20;
  localparam int RECIP_FRAC_BITS_DEF = 24;

  localparam int CNT_W      = 7;
  localparam int IDX_W      = 6;
  localparam int SCORE_BITS = 32;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RDWAIT,
    S_CSTART,
    S_CDIV,
    S_USTART,
    S_UDIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_wr;
    logic start_cls;
    logic rd_en;
    logic latch_entry;
    logic div_start;
    logic div_sel_u;
    logic add_c;
    logic add_u;
    logic next_idx;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic idx_end;
    logic c_eq;
    logic u_eq;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/core/wnntc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnntc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module wnntc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/wnntc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnntc_ctrl
// Sequencer: accepts items, walks the reference entries and starts the shared
// reciprocal divider for each term not skipped by an exact hit.
// ----------------------------------------------------------------------------
module wnntc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_opcode,
  output logic              in_ready,
  input  wnntc_pkg::sts_t   sts,
  output wnntc_pkg::cmd_t   cmd
);

  wnntc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wnntc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wnntc_pkg::S_IDLE: begin
        if (in_valid && in_opcode == wnntc_pkg::OP_CLASSIFY) begin
          state_nxt = wnntc_pkg::S_CHECK;
        end
      end
      wnntc_pkg::S_CHECK: begin
        state_nxt = sts.idx_end ? wnntc_pkg::S_DONE : wnntc_pkg::S_RDWAIT;
      end
      wnntc_pkg::S_RDWAIT: state_nxt = wnntc_pkg::S_CSTART;
      wnntc_pkg::S_CSTART: begin
        state_nxt = sts.c_eq ? wnntc_pkg::S_CHECK : wnntc_pkg::S_CDIV;
      end
      wnntc_pkg::S_CDIV: begin
        if (sts.div_done) begin
          state_nxt = wnntc_pkg::S_USTART;
        end
      end
      wnntc_pkg::S_USTART: begin
        state_nxt = sts.u_eq ? wnntc_pkg::S_CHECK : wnntc_pkg::S_UDIV;
      end
      wnntc_pkg::S_UDIV: begin
        if (sts.div_done) begin
          state_nxt = wnntc_pkg::S_CHECK;
        end
      end
      wnntc_pkg::S_DONE: begin
        if (sts.out_free) begin
          state_nxt = wnntc_pkg::S_IDLE;
        end
      end
      default: state_nxt = wnntc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      wnntc_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_wr   = in_valid && in_opcode == wnntc_pkg::OP_LOAD;
        cmd.start_cls = in_valid && in_opcode == wnntc_pkg::OP_CLASSIFY;
      end
      wnntc_pkg::S_CHECK:  cmd.rd_en = !sts.idx_end;
      wnntc_pkg::S_RDWAIT: cmd.latch_entry = 1'b1;
      wnntc_pkg::S_CSTART: begin
        cmd.div_start = !sts.c_eq;
        cmd.next_idx  = sts.c_eq;
      end
      wnntc_pkg::S_CDIV:   cmd.add_c = sts.div_done;
      wnntc_pkg::S_USTART: begin
        cmd.div_start = !sts.u_eq;
        cmd.div_sel_u = 1'b1;
        cmd.next_idx  = sts.u_eq;
      end
      wnntc_pkg::S_UDIV: begin
        cmd.add_u    = sts.div_done;
        cmd.next_idx = sts.div_done;
      end
      wnntc_pkg::S_DONE:   cmd.load_result = sts.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/core/wnntc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnntc_dp
// Datapath: reference table RAM, entry index, bit-serial reciprocal divider,
// saturating score accumulators, count register and output register.
// ----------------------------------------------------------------------------
module wnntc_dp #(
  parameter int MAX_SAMPLES     = wnntc_pkg::MAX_SAMPLES_DEF,
  parameter int TIME_BITS       = wnntc_pkg::TIME_BITS_DEF,
  parameter int RECIP_FRAC_BITS = wnntc_pkg::RECIP_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wnntc_pkg::cmd_t             cmd,
  output wnntc_pkg::sts_t             sts,
  input  logic                        cfg_valid,
  input  logic [wnntc_pkg::CNT_W-1:0] cfg_sample_count,
  input  logic [wnntc_pkg::IDX_W-1:0] in_entry_index,
  input  logic [TIME_BITS-1:0]        in_cached_ref_time,
  input  logic [TIME_BITS-1:0]        in_uncached_ref_time,
  input  logic [TIME_BITS-1:0]        in_measured_delay,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        out_is_cached
);

  localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int QW   = RECIP_FRAC_BITS + 1;
  localparam int STW  = $clog2(RECIP_FRAC_BITS + 1);
  localparam int SB   = wnntc_pkg::SCORE_BITS;
  localparam int SUMW = ((QW > SB) ? QW : SB) + 1;

  logic [wnntc_pkg::CNT_W-1:0] count_r;
  logic [TIME_BITS-1:0]        delay_r;
  logic [CW-1:0]               n_r;
  logic [CW-1:0]               idx_r;
  logic [TIME_BITS-1:0]        ent_c_r, ent_u_r;
  logic [SB-1:0]               cs_r, us_r;
  logic [TIME_BITS-1:0]        div_r;
  logic [TIME_BITS-1:0]        rem_r, rem_nxt;
  logic [QW-1:0]               quo_r, quo_nxt;
  logic [STW-1:0]              step_r;
  logic                        busy_r, done_r;
  logic                        out_valid_r, out_r;

  logic [2*TIME_BITS-1:0] rdata;
  logic [TIME_BITS-1:0]   dist_c, dist_u;
  logic [TIME_BITS:0]     shifted;
  logic                   ge;
  logic                   last_step;
  logic [SB-1:0]          add_src, add_sat;
  logic [SUMW-1:0]        sum;
  logic [CW-1:0]          n_clip;
  logic                   idx_ok;

  assign idx_ok = 32'(in_entry_index) < MAX_SAMPLES;

  wnntc_ram #(
    .WIDTH (2 * TIME_BITS),
    .DEPTH (MAX_SAMPLES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.load_wr && idx_ok),
    .waddr (AW'(in_entry_index)),
    .wdata ({in_cached_ref_time, in_uncached_ref_time}),
    .re    (cmd.rd_en),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  assign n_clip = (32'(count_r) > MAX_SAMPLES) ? CW'(MAX_SAMPLES) : CW'(count_r);

  assign dist_c = (delay_r >= ent_c_r) ? delay_r - ent_c_r : ent_c_r - delay_r;
  assign dist_u = (delay_r >= ent_u_r) ? delay_r - ent_u_r : ent_u_r - delay_r;

  // restoring division of 2^RECIP_FRAC_BITS, one quotient bit per cycle
  assign shifted   = {rem_r, step_r == '0};
  assign ge        = shifted >= {1'b0, div_r};
  assign rem_nxt   = ge ? TIME_BITS'(shifted - {1'b0, div_r}) : TIME_BITS'(shifted);
  assign quo_nxt   = {quo_r[QW-2:0], ge};
  assign last_step = step_r == STW'(RECIP_FRAC_BITS);

  assign add_src = cmd.add_u ? us_r : cs_r;
  assign sum     = SUMW'(add_src) + SUMW'(quo_r);
  assign add_sat = (sum > SUMW'({SB{1'b1}})) ? {SB{1'b1}} : sum[SB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        count_r <= cfg_sample_count;
      end
      done_r <= busy_r && last_step;
      if (cmd.div_start) begin
        busy_r <= 1'b1;
      end else if (last_step) begin
        busy_r <= 1'b0;
      end
      if (cmd.load_result) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_cls) begin
      delay_r <= in_measured_delay;
      n_r     <= n_clip;
      idx_r   <= '0;
      cs_r    <= '0;
      us_r    <= '0;
    end
    if (cmd.next_idx) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.latch_entry) begin
      ent_c_r <= rdata[2*TIME_BITS-1:TIME_BITS];
      ent_u_r <= rdata[TIME_BITS-1:0];
    end
    if (cmd.div_start) begin
      div_r  <= cmd.div_sel_u ? dist_u : dist_c;
      rem_r  <= '0;
      quo_r  <= '0;
      step_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      step_r <= step_r + STW'(1);
    end
    if (cmd.add_c) begin
      cs_r <= add_sat;
    end
    if (cmd.add_u) begin
      us_r <= add_sat;
    end
    if (cmd.load_result) begin
      out_r <= cs_r > us_r;
    end
  end

  assign sts.idx_end  = idx_r == n_r;
  assign sts.c_eq     = delay_r == ent_c_r;
  assign sts.u_eq     = delay_r == ent_u_r;
  assign sts.div_busy = busy_r;
  assign sts.div_done = done_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_is_cached = out_r;

endmodule

// ----- rtl/core/weighted_nn_timing_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_nn_timing_classifier
// Inverse-distance weighted nearest-neighbor classifier of measured delays.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : write sample_count while the block is idle; cfg_ready is always 1.
//   in_*   : one item per transfer. Opcode load writes a reference pair at
//            in_entry_index (dropped if beyond the table) and gives no result.
//            Opcode classify scores in_measured_delay against the first
//            min(sample_count, MAX_SAMPLES) entries.
//   out_*  : one out_is_cached per classify, held in an output register.
// Classify time is set by the shared bit-serial reciprocal divider, one
//   division per term; an entry whose cached ref equals the delay skips
//   both its divisions, one whose uncached ref equals it skips that one.
// Throughput: loads back to back, one per cycle; after a classify the next
//   item is taken in the cycle after its result is loaded.
// One item at a time: in_ready is high only while the sequencer is idle.
// A finished result waits in the output register; the next item is accepted
// while it waits, but a second result stalls until out_ready takes the first.
// Reset clears sample_count, the sequencer and out_valid; table contents are
// undefined until loaded.
// ----------------------------------------------------------------------------
module weighted_nn_timing_classifier #(
  parameter int MAX_SAMPLES     = wnntc_pkg::MAX_SAMPLES_DEF,
  parameter int TIME_BITS       = wnntc_pkg::TIME_BITS_DEF,
  parameter int RECIP_FRAC_BITS = wnntc_pkg::RECIP_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wnntc_pkg::CNT_W-1:0] cfg_sample_count,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [wnntc_pkg::IDX_W-1:0] in_entry_index,
  input  logic [TIME_BITS-1:0]        in_cached_ref_time,
  input  logic [TIME_BITS-1:0]        in_uncached_ref_time,
  input  logic [TIME_BITS-1:0]        in_measured_delay,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_is_cached
);

  wnntc_pkg::cmd_t cmd;
  wnntc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  wnntc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wnntc_dp #(
    .MAX_SAMPLES     (MAX_SAMPLES),
    .TIME_BITS       (TIME_BITS),
    .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_valid            (cfg_valid),
    .cfg_sample_count     (cfg_sample_count),
    .in_entry_index       (in_entry_index),
    .in_cached_ref_time   (in_cached_ref_time),
    .in_uncached_ref_time (in_uncached_ref_time),
    .in_measured_delay    (in_measured_delay),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_is_cached        (out_is_cached)
  );

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !sts.div_busy)
    else $error("item accepted while divider busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |=> !sts.div_done)
    else $error("divider done held longer than one cycle");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.div_start, cmd.add_c, cmd.add_u, cmd.load_result, cmd.start_cls}))
    else $error("conflicting datapath commands");

  a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_result |-> (!out_valid || out_ready))
    else $error("result overwrote an untaken result");

endmodule

// ----- tb/sv/weighted_nn_timing_classifier_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_nn_timing_classifier_checker
// Watches the config, input and result channels of the timing classifier,
// keeps its own reference tables and sample count, predicts the cached/
// uncached verdict of every classify transfer and compares each result
// transfer in order against the oldest pending verdict.
// ----------------------------------------------------------------------------
module weighted_nn_timing_classifier_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [wnntc_pkg::CNT_W-1:0]           cfg_sample_count,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic                                  in_opcode,
  input  logic [wnntc_pkg::IDX_W-1:0]           in_entry_index,
  input  logic [wnntc_pkg::TIME_BITS_DEF-1:0]   in_cached_ref_time,
  input  logic [wnntc_pkg::TIME_BITS_DEF-1:0]   in_uncached_ref_time,
  input  logic [wnntc_pkg::TIME_BITS_DEF-1:0]   in_measured_delay,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic                                  out_is_cached,
  output int                                    mismatch_count,
  output int                                    verdicts_outstanding
);

  localparam int TW     = wnntc_pkg::TIME_BITS_DEF;
  localparam int NMAX   = wnntc_pkg::MAX_SAMPLES_DEF;
  localparam int RFRAC  = wnntc_pkg::RECIP_FRAC_BITS_DEF;
  localparam longint unsigned SCORE_CEIL = 64'hFFFF_FFFF;

  logic [TW-1:0]               cached_ref   [NMAX];
  logic [TW-1:0]               uncached_ref [NMAX];
  logic [wnntc_pkg::CNT_W-1:0] pair_count = '0;
  bit                          verdict_queue[$];
  int                          error_total = 0;
  bit                          want;

  function automatic longint unsigned inverse_distance(logic [TW-1:0] a, logic [TW-1:0] b);
    longint unsigned span;
    span = (a > b) ? (a - b) : (b - a);
    if (span == 0) return 0;
    return (64'd1 << RFRAC) / span;
  endfunction

  function automatic longint unsigned score_add(longint unsigned s, longint unsigned v);
    longint unsigned t;
    t = s + v;
    return (t > SCORE_CEIL) ? SCORE_CEIL : t;
  endfunction

  function automatic bit predict_cached_verdict(logic [TW-1:0] delay);
    longint unsigned c_score;
    longint unsigned u_score;
    int              n;
    c_score = 0;
    u_score = 0;
    n = (pair_count > NMAX) ? NMAX : int'(pair_count);
    for (int i = 0; i < n; i++) begin
      // exact hit on the cached ref drops both terms of the pair
      if (delay == cached_ref[i]) continue;
      c_score = score_add(c_score, inverse_distance(delay, cached_ref[i]));
      if (delay == uncached_ref[i]) continue;
      u_score = score_add(u_score, inverse_distance(delay, uncached_ref[i]));
    end
    return c_score > u_score;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) pair_count = cfg_sample_count;
      if (in_valid && in_ready) begin
        if (in_opcode == wnntc_pkg::OP_LOAD) begin
          if (in_entry_index < NMAX) begin
            cached_ref[in_entry_index]   = in_cached_ref_time;
            uncached_ref[in_entry_index] = in_uncached_ref_time;
          end
        end else begin
          verdict_queue.push_back(predict_cached_verdict(in_measured_delay));
        end
      end
      if (out_valid && out_ready) begin
        if (verdict_queue.size() == 0) begin
          $display("%0t: unexpected is_cached transfer, expected none, actual %0b",
                   $time, out_is_cached);
          error_total++;
        end else begin
          want = verdict_queue.pop_front();
          if (out_is_cached !== want) begin
            $display("%0t: is_cached mismatch, expected %0b, actual %0b",
                     $time, want, out_is_cached);
            error_total++;
          end
        end
      end
    end
    mismatch_count       <= error_total;
    verdicts_outstanding <= verdict_queue.size();
  end

endmodule

// ----- tb/sv/weighted_nn_timing_classifier_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_nn_timing_classifier_tb
// Drives the timing classifier with directed corner cases (empty count,
// exact hits on either reference, field extremes) and then phases of random
// loads and classifies over several sample counts, with random gaps on the
// input and result channels. A checker predicts and compares the results.
// ----------------------------------------------------------------------------
module weighted_nn_timing_classifier_tb;

  localparam int TW           = wnntc_pkg::TIME_BITS_DEF;
  localparam int NMAX         = wnntc_pkg::MAX_SAMPLES_DEF;
  localparam int CW           = wnntc_pkg::CNT_W;
  localparam int IW           = wnntc_pkg::IDX_W;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int RANDOM_ITEMS = 160;
  localparam int SETTLE       = 10;
  localparam logic [TW-1:0] TIME_MAX = '1;

  logic          clk;
  logic          rst_n;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [CW-1:0] cfg_sample_count;
  logic          in_valid;
  logic          in_ready;
  logic          in_opcode;
  logic [IW-1:0] in_entry_index;
  logic [TW-1:0] in_cached_ref_time;
  logic [TW-1:0] in_uncached_ref_time;
  logic [TW-1:0] in_measured_delay;
  logic          out_valid;
  logic          out_ready;
  logic          out_is_cached;

  int mismatch_count;
  int verdicts_outstanding;
  int cycle_count = 0;
  bit quiet = 1'b0;
  int active_pairs = 0;
  int random_sent;

  logic [TW-1:0] cached_shadow   [NMAX];
  logic [TW-1:0] uncached_shadow [NMAX];
  bit            loaded          [NMAX];

  int phase_counts[15] = '{3, 1, 12, 0, 64, 5, 127, 2, 20, 65, 8, 40, 4, 100, 6};

  weighted_nn_timing_classifier dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_sample_count     (cfg_sample_count),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opcode            (in_opcode),
    .in_entry_index       (in_entry_index),
    .in_cached_ref_time   (in_cached_ref_time),
    .in_uncached_ref_time (in_uncached_ref_time),
    .in_measured_delay    (in_measured_delay),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_is_cached        (out_is_cached)
  );

  weighted_nn_timing_classifier_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_sample_count     (cfg_sample_count),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opcode            (in_opcode),
    .in_entry_index       (in_entry_index),
    .in_cached_ref_time   (in_cached_ref_time),
    .in_uncached_ref_time (in_uncached_ref_time),
    .in_measured_delay    (in_measured_delay),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_is_cached        (out_is_cached),
    .mismatch_count       (mismatch_count),
    .verdicts_outstanding (verdicts_outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** weighted_nn_timing_classifier: FAILED **");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  function automatic logic [TW-1:0] rand_time();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return TIME_MAX;
    return TW'($urandom);
  endfunction

  // mostly near a stored ref, so exact hits and close calls are common
  function automatic logic [TW-1:0] pick_delay();
    int r;
    int k;
    r = $urandom_range(0, 99);
    k = (active_pairs > 0) ? $urandom_range(0, active_pairs - 1) : 0;
    if (active_pairs == 0 || r >= 75) return rand_time();
    if (r < 20) return cached_shadow[k];
    if (r < 35) return uncached_shadow[k];
    if (r < 55) return cached_shadow[k] + TW'($urandom_range(0, 64)) - TW'(32);
    return uncached_shadow[k] + TW'($urandom_range(0, 64)) - TW'(32);
  endfunction

  task automatic send_item(logic op, logic [IW-1:0] idx, logic [TW-1:0] c_ref,
                           logic [TW-1:0] u_ref, logic [TW-1:0] delay);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_opcode            <= op;
    in_entry_index       <= idx;
    in_cached_ref_time   <= c_ref;
    in_uncached_ref_time <= u_ref;
    in_measured_delay    <= delay;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_entry(logic [IW-1:0] idx, logic [TW-1:0] c_ref, logic [TW-1:0] u_ref);
    loaded[idx]          = 1'b1;
    cached_shadow[idx]   = c_ref;
    uncached_shadow[idx] = u_ref;
    send_item(wnntc_pkg::OP_LOAD, idx, c_ref, u_ref, TW'($urandom));
  endtask

  task automatic classify_delay(logic [TW-1:0] delay);
    send_item(wnntc_pkg::OP_CLASSIFY, IW'($urandom), TW'($urandom), TW'($urandom), delay);
  endtask

  // half the pairs clustered (cached refs a bit below uncached ones), the rest random
  task automatic random_load(int idx);
    if ($urandom_range(0, 1) == 0)
      load_entry(IW'(idx), TW'(1000 + $urandom_range(0, 400)),
                 TW'(1500 + $urandom_range(0, 800)));
    else
      load_entry(IW'(idx), rand_time(), rand_time());
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdicts_outstanding != 0);
  endtask

  task automatic set_pair_count(int count);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_sample_count <= CW'(count);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    active_pairs = (count > NMAX) ? NMAX : count;
  endtask

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      int stall;
      if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        stall = gap_len();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int n_items;
    int count;
    rst_n                = 1'b0;
    cfg_valid            = 1'b0;
    cfg_sample_count     = '0;
    in_valid             = 1'b0;
    in_opcode            = wnntc_pkg::OP_LOAD;
    in_entry_index       = '0;
    in_cached_ref_time   = '0;
    in_uncached_ref_time = '0;
    in_measured_delay    = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // count of zero right after reset
    classify_delay('0);
    classify_delay(TIME_MAX);
    set_pair_count(1);
    load_entry(0, 100, 200);
    classify_delay(100);
    classify_delay(200);
    classify_delay(150);
    classify_delay('0);
    classify_delay(TIME_MAX);
    load_entry(0, TIME_MAX, '0);
    classify_delay(TIME_MAX);
    classify_delay('0);
    load_entry(0, 5, 5);
    classify_delay(5);
    set_pair_count(2);
    load_entry(1, '0, TIME_MAX);
    classify_delay('0);
    classify_delay(3);
    load_entry(IW'(NMAX - 1), 7, 9);

    random_sent = 0;
    for (int p = 0; random_sent < RANDOM_ITEMS; p++) begin
      quiet = ($urandom_range(0, 4) == 0);
      count = (p < 15) ? phase_counts[p] : $urandom_range(0, 12);
      set_pair_count(count);
      for (int i = 0; i < active_pairs; i++) begin
        if (!loaded[i]) begin
          random_load(i);
          random_sent++;
        end
      end
      n_items = (active_pairs >= 32) ? 6 : 15;
      repeat (n_items) begin
        if ($urandom_range(0, 29) == 0) drain_results();
        if ($urandom_range(0, 3) == 0) random_load($urandom_range(0, NMAX - 1));
        else classify_delay(pick_delay());
        random_sent++;
      end
    end

    quiet = 1'b0;
    drain_results();
    repeat (2 * SETTLE) @(posedge clk);
    if (mismatch_count == 0)
      $display("** weighted_nn_timing_classifier: PASSED **");
    else
      $display("** weighted_nn_timing_classifier: FAILED **");
    $finish;
  end

endmodule
